// File: sv/min_tracking_stack_top_assert.svh
// Assertion macros for the min tracking stack.
// Used by min_tracking_stack_top; no other dependencies.
`ifndef MIN_TRACKING_STACK_TOP_ASSERT_SVH
`define MIN_TRACKING_STACK_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min tracking stack assertion failed");

// Next-cycle implication, disabled in reset.
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min tracking stack assertion failed");

`endif

// File: sv/mts_pkg.sv
// Shared constants, codes and types for the min tracking stack.
// No dependencies.
package mts_pkg;

  localparam int DEF_STACK_DEPTH = 256;
  localparam int DEF_DATA_WIDTH  = 32;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

// File: sv/mts_if.sv
// Valid/ready channel interfaces for operation and result beats.
// No dependencies.
interface mts_in_if #(
  parameter int DW = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic signed [DW-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface mts_out_if #(
  parameter int DW = 32,
  parameter int CW = 9
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] result_value;
  logic signed [DW-1:0] current_min;
  logic                 is_empty;
  logic [CW-1:0]        entry_count;
  logic [1:0]           status;

  modport source (output valid, output result_value, output current_min,
                  output is_empty, output entry_count, output status, input ready);
  modport sink   (input valid, input result_value, input current_min,
                  input is_empty, input entry_count, input status, output ready);
endinterface

// File: sv/mts_cell.sv
// One stack cell: holds an encoded word, shifts down on push, up on pop.
// Depends on mts_pkg.
module mts_cell #(
  parameter int DW = mts_pkg::DEF_DATA_WIDTH
) (
  input  logic                clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  logic signed [DW:0]  above_word,
  input  logic signed [DW:0]  below_word,
  output logic signed [DW:0]  word
);
  import mts_pkg::*;

  logic signed [DW:0] word_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      word_r <= above_word;
    end else if (ctl.pop) begin
      word_r <= below_word;
    end
  end

  assign word = word_r;
endmodule

// File: sv/mts_chain.sv
// Row of stack cells; cell 0 is the top of the stack.
// Depends on mts_pkg and mts_cell.
module mts_chain #(
  parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
  parameter int DW          = mts_pkg::DEF_DATA_WIDTH
) (
  input  logic                clk,
  input  mts_pkg::shift_ctl_t ctl,
  input  logic signed [DW:0]  push_word,
  output logic signed [DW:0]  top_word
);
  import mts_pkg::*;

  logic signed [DW:0] words [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [DW:0] above;
    logic signed [DW:0] below;

    if (i == 0) begin : g_head
      assign above = push_word;
    end else begin : g_body
      assign above = words[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = '0;
    end else begin : g_link
      assign below = words[i+1];
    end

    mts_cell #(.DW(DW)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .above_word (above),
      .below_word (below),
      .word       (words[i])
    );
  end

  assign top_word = words[0];
endmodule

// File: sv/min_tracking_stack_top.sv
// Min tracking stack: LIFO of signed values that reports its minimum.
// Operation beats arrive on in_ch (opcode, push_value); every accepted
// beat yields exactly one result beat on out_ch with the top or popped
// value, the minimum, an empty flag, the entry count and a status.
// Opcodes: push, pop, query; an unused code acts as a query. Pop or query
// on an empty stack returns zeros with status empty; push on a full stack
// changes nothing and returns the top with status full.
// The result is registered and valid in the cycle after accept. Throughput
// is one beat per cycle while the receiver keeps up: each entry lives in a
// cell of a shifting row, and a push or pop moves the whole row at once, so
// only the top cell, the count and the minimum register are read per operation.
// The result register takes a new beat whenever it is empty or being
// taken in the same cycle; a stalled receiver holds the result and stops
// acceptance until it drains.
// Reset (rst_n, synchronous, active low) empties the stack, clears the
// minimum and drops any pending result. Cell contents need no reset.
// Depends on mts_pkg, mts_if, mts_cell, mts_chain and the assertion header.
`include "min_tracking_stack_top_assert.svh"

module min_tracking_stack_top #(
  parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
  parameter int DATA_WIDTH  = mts_pkg::DEF_DATA_WIDTH
) (
  input logic clk,
  input logic rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);
  import mts_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]        count_r, count_nxt;
  logic signed [DW-1:0] min_r, min_nxt;
  logic                 out_valid_r;
  logic signed [DW-1:0] res_r, res_nxt;
  logic signed [DW-1:0] omin_r;
  logic                 empty_r;
  logic [CW-1:0]        ocount_r;
  logic [1:0]           status_r, status_nxt;

  logic                 accept;
  logic                 is_full, is_zero;
  shift_ctl_t           ctl;
  logic signed [DW:0]   top_w, push_w, x_w, min_w, diff_w, sum_w, restore_w;
  logic signed [DW-1:0] top_val;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == CW'(STACK_DEPTH));
  assign is_zero     = (count_r == '0);

  assign x_w       = {in_ch.push_value[DW-1], in_ch.push_value};
  assign min_w     = {min_r[DW-1], min_r};
  assign diff_w    = x_w - min_w;
  assign sum_w     = top_w + min_w;
  assign restore_w = min_w - top_w;
  assign top_val   = top_w[DW] ? min_r : sum_w[DW-1:0];
  assign push_w    = is_zero ? '0 : diff_w;

  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    min_nxt    = min_r;
    res_nxt    = '0;
    status_nxt = ST_OK;
    case (in_ch.opcode)
      OP_PUSH: begin
        if (is_full) begin
          status_nxt = ST_FULL;
          res_nxt    = top_val;
        end else begin
          ctl.push  = 1'b1;
          count_nxt = count_r + 1'b1;
          res_nxt   = in_ch.push_value;
          if (is_zero || diff_w[DW]) begin
            min_nxt = in_ch.push_value;
          end
        end
      end
      OP_POP: begin
        if (is_zero) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.pop   = 1'b1;
          count_nxt = count_r - 1'b1;
          res_nxt   = top_val;
          if (top_w[DW]) begin
            min_nxt = restore_w[DW-1:0];
          end
          if (count_r == CW'(1)) begin
            min_nxt = '0;
          end
        end
      end
      default: begin
        if (is_zero) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_nxt = top_val;
        end
      end
    endcase
    if (!accept) begin
      ctl = '0;
    end
  end

  mts_chain #(
    .STACK_DEPTH (STACK_DEPTH),
    .DW          (DW)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .push_word (push_w),
    .top_word  (top_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        min_r       <= min_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r    <= res_nxt;
      omin_r   <= (count_nxt == '0) ? '0 : min_nxt;
      empty_r  <= (count_nxt == '0);
      ocount_r <= count_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = res_r;
  assign out_ch.current_min  = omin_r;
  assign out_ch.is_empty     = empty_r;
  assign out_ch.entry_count  = ocount_r;
  assign out_ch.status       = status_r;

  `MTS_ASSERT_NOW(a_min_clear_when_empty, clk, rst_n, is_zero, min_r == '0)
  `MTS_ASSERT_NOW(a_count_in_range, clk, rst_n, 1'b1, count_r <= CW'(STACK_DEPTH))
  `MTS_ASSERT_NEXT(a_push_grows, clk, rst_n,
                   accept && in_ch.opcode == OP_PUSH && !is_full,
                   count_r == $past(count_r) + 1'b1)
  `MTS_ASSERT_NEXT(a_pop_empty_flagged, clk, rst_n,
                   accept && in_ch.opcode == OP_POP && is_zero,
                   is_zero && status_r == ST_EMPTY && out_valid_r)
endmodule
